// File: rtl/motor_feedback_angle_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor feedback angle tracker
// Every macro expects clk and rst_n in scope and stays quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_ANGLE_TRACKER_ASSERT_SVH
`define MOTOR_FEEDBACK_ANGLE_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mfat_pkg.sv
// ----------------------------------------------------------------------------
// mfat_pkg
// Shared types and constants of the motor feedback angle tracker.
// ----------------------------------------------------------------------------
package mfat_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_CALIB  = 2'd0,
    ST_MEAS   = 2'd1,
    ST_REJECT = 2'd2,
    ST_TICK   = 2'd3
  } status_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MOTOR_BASE = 2'd0;
  localparam logic [1:0] REG_SERVO_BASE = 2'd1;
  localparam logic [1:0] REG_CALIB      = 2'd2;
  localparam logic [1:0] REG_TIMEOUT    = 2'd3;

  localparam logic [10:0] MOTOR_BASE_RST = 11'd513;
  localparam logic [10:0] SERVO_BASE_RST = 11'd517;
  localparam logic [5:0]  CALIB_RST      = 6'd50;
  localparam logic [15:0] TIMEOUT_RST    = 16'd5;

  localparam logic [10:0]        SERVO_SPLIT_ID   = 11'h209;
  localparam logic signed [12:0] SERVO_FIRST_SLOT = 13'sd4;
  localparam logic signed [16:0] JUMP_LIMIT       = 17'sd4096;
  // One turn is 8191 counts, that is 2^13 - 1.
  localparam int                 TURN_SHIFT       = 13;
  localparam int                 MAP_BITS         = 22;
  localparam int                 SLOT_W           = 5;
  localparam int                 SLOT_FULL_W      = 7;

  // One slot's tracking state, kept as a single memory word.
  typedef struct packed {
    logic [15:0] cur_angle;
    logic [15:0] offset;
    logic [31:0] turns;
    logic [5:0]  frames_seen;
    logic [31:0] last_seen_ms;
  } slot_ent_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic read;
    logic update;
    logic write;
    logic tick_rd;
    logic emit;
  } mfat_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic reject;
    logic tick_last;
  } mfat_sts_t;

endpackage

// File: rtl/mfat_ctrl.sv
// ----------------------------------------------------------------------------
// mfat_ctrl
// Sequencer that steps the datapath through a frame or a status tick.
// ----------------------------------------------------------------------------
`include "motor_feedback_angle_tracker_assert.svh"

module mfat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mfat_pkg::mfat_sts_t sts,
  output mfat_pkg::mfat_cmd_t cmd
);
  import mfat_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_CALC   = 8'b0000_1000,
    S_WRITE  = 8'b0001_0000,
    S_TICK   = 8'b0010_0000,
    S_DRAIN  = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.is_tick) begin
          state_nxt = S_TICK;
        end else if (sts.reject) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.update = 1'b1;
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_EMIT;
      end
      S_TICK: begin
        cmd.tick_rd = 1'b1;
        if (sts.tick_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last slot's age check lands at the end of this cycle.
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  `MFAT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `MFAT_ASSERT_NEXT(a_emit_idle, cmd.emit, !busy, "controller not idle after a result")
  `MFAT_ASSERT_SAME(a_write_after_update, cmd.write, $past(cmd.update),
                    "slot written without a preceding update")

endmodule

// File: rtl/mfat_dp.sv
// ----------------------------------------------------------------------------
// mfat_dp
// Slot state memory, frame decode, turn tracking and online map datapath.
// ----------------------------------------------------------------------------
`include "motor_feedback_angle_tracker_assert.svh"

module mfat_dp #(
  parameter int SLOTS_PER_BUS = 11,
  parameter int BUSES         = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mfat_pkg::mfat_cmd_t cmd,
  output mfat_pkg::mfat_sts_t sts,
  input  logic [10:0]         motor_base_id,
  input  logic [10:0]         servo_base_id,
  input  logic [5:0]          calib_frames,
  input  logic [15:0]         timeout_ms,
  input  logic                in_kind,
  input  logic                in_bus,
  input  logic [10:0]         in_frame_id,
  input  logic [63:0]         in_payload,
  input  logic [31:0]         in_now_ms,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [4:0]          out_slot,
  output logic [15:0]         out_angle,
  output logic signed [15:0]  out_speed,
  output logic signed [15:0]  out_current,
  output logic [7:0]          out_temperature,
  output logic signed [31:0]  out_unwrapped_angle,
  output logic [21:0]         out_online_map
);
  import mfat_pkg::*;

  localparam int N  = SLOTS_PER_BUS * BUSES;
  localparam int SW = (N > 1) ? $clog2(N) : 1;

  // Captured item.
  logic        kind_r;
  logic        bus_r;
  logic [10:0] fid_r;
  logic [15:0] ang_r;
  logic [15:0] speed_r;
  logic [15:0] curr_r;
  logic [7:0]  temp_r;
  logic [31:0] now_r;

  // Decode results.
  logic [SLOT_FULL_W-1:0] slot_r;
  logic                   reject_r;
  logic signed [12:0]     idx;
  logic                   reject_nxt;
  logic [SLOT_FULL_W-1:0] slot_nxt;

  // Slot memory with per-entry valid bits; an unwritten slot reads as zero.
  slot_ent_t   mem [N];
  logic [N-1:0] valid_r;
  slot_ent_t   rd_data_r;
  logic        rd_vld_r;
  logic [SW-1:0] rd_addr;
  slot_ent_t   ent;

  // Update stage.
  slot_ent_t          new_ent_r, new_ent_nxt;
  logic               calib_r, calib_nxt;
  logic signed [16:0] diff;
  logic [31:0]        scaled_r;
  logic [31:0]        ao_r;

  // Tick walk.
  logic [SW-1:0]       tcnt_r;
  logic                chk_v_r;
  logic [SW-1:0]       chk_idx_r;
  logic [MAP_BITS-1:0] map_r;
  logic [MAP_BITS-1:0] map_hit;
  logic [31:0]         age;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      bus_r   <= in_bus;
      fid_r   <= in_frame_id;
      ang_r   <= in_payload[63:48];
      speed_r <= in_payload[47:32];
      curr_r  <= in_payload[31:16];
      temp_r  <= in_payload[15:8];
      now_r   <= in_now_ms;
    end
  end

  // Identifiers from the split point upward count from the servo base plus four.
  always_comb begin
    if (fid_r < SERVO_SPLIT_ID) begin
      idx = $signed({2'b00, fid_r}) - $signed({2'b00, motor_base_id});
    end else begin
      idx = $signed({2'b00, fid_r}) - $signed({2'b00, servo_base_id}) + SERVO_FIRST_SLOT;
    end
    reject_nxt = (32'(bus_r) >= BUSES) || idx[12] || (idx >= 13'(SLOTS_PER_BUS));
    slot_nxt   = SLOT_FULL_W'(idx[4:0]) +
                 (bus_r ? SLOT_FULL_W'(SLOTS_PER_BUS) : SLOT_FULL_W'(0));
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      reject_r <= reject_nxt;
      slot_r   <= slot_nxt;
    end
  end

  assign sts.is_tick   = kind_r;
  assign sts.reject    = reject_nxt;
  assign sts.tick_last = (tcnt_r == SW'(N - 1));

  assign rd_addr = cmd.tick_rd ? tcnt_r : slot_r[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.read || cmd.tick_rd) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
    end
    if (cmd.write) begin
      mem[slot_r[SW-1:0]] <= new_ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.write) begin
      valid_r[slot_r[SW-1:0]] <= 1'b1;
    end
  end

  assign ent = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    calib_nxt   = (ent.frames_seen <= calib_frames);
    diff        = $signed({1'b0, ang_r}) - $signed({1'b0, ent.cur_angle});
    new_ent_nxt = ent;
    new_ent_nxt.cur_angle = ang_r;
    if (calib_nxt) begin
      new_ent_nxt.offset      = ang_r;
      new_ent_nxt.frames_seen = ent.frames_seen + 6'd1;
    end else begin
      new_ent_nxt.last_seen_ms = now_r;
      if (diff > JUMP_LIMIT) begin
        new_ent_nxt.turns = ent.turns - 32'd1;
      end else if (diff < -JUMP_LIMIT) begin
        new_ent_nxt.turns = ent.turns + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      new_ent_r <= new_ent_nxt;
      calib_r   <= calib_nxt;
    end
    if (cmd.write) begin
      scaled_r <= (new_ent_r.turns << TURN_SHIFT) - new_ent_r.turns;
      ao_r     <= 32'($signed({1'b0, ang_r}) - $signed({1'b0, new_ent_r.offset}));
    end
  end

  // Tick walk: one slot read per cycle, its age checked in the cycle after its read.
  assign age = now_r - ent.last_seen_ms;

  always_comb begin
    map_hit = '0;
    for (int i = 0; i < MAP_BITS; i++) begin
      if ((i < N) && (chk_idx_r == SW'(i))) begin
        map_hit[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcnt_r  <= '0;
      chk_v_r <= 1'b0;
    end else begin
      chk_v_r <= cmd.tick_rd;
      if (cmd.load) begin
        tcnt_r <= '0;
      end else if (cmd.tick_rd) begin
        tcnt_r <= tcnt_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_rd) begin
      chk_idx_r <= tcnt_r;
    end
    if (cmd.load) begin
      map_r <= '0;
    end else if (chk_v_r && (age <= {16'd0, timeout_ms})) begin
      map_r <= map_r | map_hit;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot            <= '0;
      out_angle           <= '0;
      out_speed           <= '0;
      out_current         <= '0;
      out_temperature     <= '0;
      out_unwrapped_angle <= '0;
      out_online_map      <= '0;
      if (kind_r) begin
        out_status     <= ST_TICK;
        out_online_map <= map_r;
      end else if (reject_r) begin
        out_status <= ST_REJECT;
      end else if (calib_r) begin
        out_status <= ST_CALIB;
        out_slot   <= slot_r[SLOT_W-1:0];
        out_angle  <= ang_r;
      end else begin
        out_status          <= ST_MEAS;
        out_slot            <= slot_r[SLOT_W-1:0];
        out_angle           <= ang_r;
        out_speed           <= speed_r;
        out_current         <= curr_r;
        out_temperature     <= temp_r;
        out_unwrapped_angle <= scaled_r + ao_r;
      end
    end
  end

  `MFAT_ASSERT_SAME(a_no_write_rejected, cmd.write, !reject_r && !kind_r,
                    "slot memory written for a rejected frame or a tick")
  `MFAT_ASSERT_NEXT(a_write_sets_valid, cmd.write, valid_r[slot_r[SW-1:0]],
                    "written slot not marked valid")
  `MFAT_ASSERT_SAME(a_tick_fields_zero, out_valid && (out_status == ST_TICK),
                    (out_slot == 5'd0) && (out_unwrapped_angle == 32'sd0),
                    "tick report carries frame fields")

endmodule

// File: rtl/motor_feedback_angle_tracker.sv
// ----------------------------------------------------------------------------
// motor_feedback_angle_tracker
// Multi-turn angle tracking for motor feedback frames on several buses.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// its single result has been placed on the out_ ports, where it is shown for
// exactly one cycle with out_valid and must be taken then, as nothing can
// hold it. A feedback frame steps through the decode, read, update, write and
// emit states (a rejected identifier only through decode and emit), and the
// next item waits until it is done. A status tick walks the per-slot state
// memory one slot per cycle through its single read port. Slot state reads as
// zero after reset through per-slot valid bits, so no clearing pass is needed
// and the block accepts items right away.
// Registers: 0x0 motor_base_id, 0x4 servo_base_id, 0x8 calib_frames,
// 0xC timeout_ms; write them only while busy is low.
// ----------------------------------------------------------------------------
module motor_feedback_angle_tracker #(
  parameter int SLOTS_PER_BUS = 11,
  parameter int BUSES         = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic               in_bus,
  input  logic [10:0]        in_frame_id,
  input  logic [63:0]        in_payload,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [4:0]         out_slot,
  output logic [15:0]        out_angle,
  output logic signed [15:0] out_speed,
  output logic signed [15:0] out_current,
  output logic [7:0]         out_temperature,
  output logic signed [31:0] out_unwrapped_angle,
  output logic [21:0]        out_online_map
);
  import mfat_pkg::*;

  logic [10:0] motor_base_r;
  logic [10:0] servo_base_r;
  logic [5:0]  calib_r;
  logic [15:0] timeout_r;
  logic        wr_en;
  mfat_cmd_t   cmd;
  mfat_sts_t   sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_base_r <= MOTOR_BASE_RST;
      servo_base_r <= SERVO_BASE_RST;
      calib_r      <= CALIB_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MOTOR_BASE: motor_base_r <= pwdata[10:0];
        REG_SERVO_BASE: servo_base_r <= pwdata[10:0];
        REG_CALIB:      calib_r      <= pwdata[5:0];
        REG_TIMEOUT:    timeout_r    <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MOTOR_BASE: prdata = {21'd0, motor_base_r};
      REG_SERVO_BASE: prdata = {21'd0, servo_base_r};
      REG_CALIB:      prdata = {26'd0, calib_r};
      REG_TIMEOUT:    prdata = {16'd0, timeout_r};
      default:        prdata = '0;
    endcase
  end

  mfat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  mfat_dp #(
    .SLOTS_PER_BUS (SLOTS_PER_BUS),
    .BUSES         (BUSES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .motor_base_id       (motor_base_r),
    .servo_base_id       (servo_base_r),
    .calib_frames        (calib_r),
    .timeout_ms          (timeout_r),
    .in_kind             (in_kind),
    .in_bus              (in_bus),
    .in_frame_id         (in_frame_id),
    .in_payload          (in_payload),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_slot            (out_slot),
    .out_angle           (out_angle),
    .out_speed           (out_speed),
    .out_current         (out_current),
    .out_temperature     (out_temperature),
    .out_unwrapped_angle (out_unwrapped_angle),
    .out_online_map      (out_online_map)
  );

endmodule
